### hdl/csf_pkg.sv
// Shared types and constants of the CSV field splitter.
`default_nettype none
package csf_pkg;

	localparam int MAX_ROW_BYTES = 65536;
	localparam int ROW_CNT_W     = $clog2(MAX_ROW_BYTES + 1);
	localparam int POS_W         = 16;
	localparam int END_W         = POS_W + 1;
	localparam int APB_AW        = 4;
	localparam int APB_DW        = 32;
	localparam int Q_DEPTH       = 2;
	localparam int Q_AW          = $clog2(Q_DEPTH);
	localparam int Q_CW          = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] TERM_RESET = 8'h09;
	localparam logic [7:0] ENC_RESET  = 8'h00;
	localparam logic [7:0] ESC_RESET  = 8'h5c;

	typedef enum logic [1:0] {
		REG_TERM = 2'd0,
		REG_ENC  = 2'd1,
		REG_ESC  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] term;
		logic [7:0] enc;
		logic [7:0] esc;
	} cfg_t;

	// One field request from the parser to the result stage.
	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [END_W-1:0] stop;
		logic             enclosed;
		logic             last;
		logic             ovf;
	} field_req_t;

endpackage
`default_nettype wire

### hdl/csf_regs.sv
// APB configuration registers of the CSV field splitter.
`default_nettype none
module csf_regs (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [csf_pkg::APB_AW-1:0]    paddr,
	input  wire  [csf_pkg::APB_DW-1:0]    pwdata,
	output logic [csf_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output csf_pkg::cfg_t                 cfg
);

	csf_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.term <= csf_pkg::TERM_RESET;
			cfg_q.enc  <= csf_pkg::ENC_RESET;
			cfg_q.esc  <= csf_pkg::ESC_RESET;
		end else if (wr_en) begin
			unique case (idx)
				csf_pkg::REG_TERM: cfg_q.term <= pwdata[7:0];
				csf_pkg::REG_ENC:  cfg_q.enc  <= pwdata[7:0];
				csf_pkg::REG_ESC:  cfg_q.esc  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			csf_pkg::REG_TERM: prdata[7:0] = cfg_q.term;
			csf_pkg::REG_ENC:  prdata[7:0] = cfg_q.enc;
			csf_pkg::REG_ESC:  prdata[7:0] = cfg_q.esc;
			default:           prdata      = '0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/csf_front.sv
// Byte parser: tracks escape and enclosure state and issues field requests.
`default_nettype none
module csf_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  csf_pkg::cfg_t        cfg,
	input  wire                  in_valid,
	input  wire  [7:0]           in_byte,
	input  wire                  in_last,
	output logic                 in_ready,
	output logic                 req_push,
	output csf_pkg::field_req_t  req,
	input  wire                  q_full
);

	logic                           esc_q;
	logic                           enc_open_q;
	logic                           enclosed_q;
	logic [csf_pkg::POS_W-1:0]      start_q;
	logic [csf_pkg::POS_W-1:0]      pos_q;
	logic                           ovf_q;
	logic [csf_pkg::ROW_CNT_W-1:0]  row_bytes_q;

	logic                           take;
	logic                           row_full;
	logic                           ovf_nx;
	logic [csf_pkg::POS_W-1:0]      pos_nx;
	logic                           at_start;
	logic                           is_esc;
	logic                           is_enc;
	logic                           is_term;
	logic                           esc_nx;
	logic                           enc_open_nx;
	logic                           enclosed_nx;

	assign in_ready = ~q_full;
	assign take     = in_valid & in_ready;
	assign row_full = (row_bytes_q == csf_pkg::ROW_CNT_W'(csf_pkg::MAX_ROW_BYTES));
	assign ovf_nx   = ovf_q | row_full;
	assign pos_nx   = (&pos_q) ? pos_q : pos_q + 1'b1;
	assign at_start = (pos_q == start_q);

	// Priority: escape, then enclosure, then terminator.
	assign is_esc  = (in_byte == cfg.esc);
	assign is_enc  = ~is_esc & (in_byte == cfg.enc) & ~esc_q & (at_start | enc_open_q);
	assign is_term = ~is_esc & ~is_enc & (in_byte == cfg.term) & ~enc_open_q & ~esc_q;

	always_comb begin
		esc_nx      = esc_q;
		enc_open_nx = enc_open_q;
		enclosed_nx = enclosed_q;
		if (is_esc) begin
			esc_nx = ~esc_q;
		end else if (is_enc) begin
			enc_open_nx = ~enc_open_q;
			if (at_start)
				enclosed_nx = 1'b1;
		end else if (is_term) begin
			enclosed_nx = 1'b0;
		end else begin
			esc_nx = 1'b0;
		end
	end

	// A terminator ends the field before itself; a bare row end includes this byte.
	always_comb begin
		req.start    = start_q;
		req.last     = in_last;
		req.ovf      = ovf_nx;
		if (is_term) begin
			req.stop     = {1'b0, pos_q};
			req.enclosed = enclosed_q;
		end else begin
			req.stop     = {1'b0, pos_q} + 1'b1;
			req.enclosed = enclosed_nx;
		end
	end

	assign req_push = take & (is_term | in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= 1'b0;
			enc_open_q  <= 1'b0;
			enclosed_q  <= 1'b0;
			start_q     <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			row_bytes_q <= '0;
		end else if (take) begin
			if (in_last) begin
				esc_q       <= 1'b0;
				enc_open_q  <= 1'b0;
				enclosed_q  <= 1'b0;
				start_q     <= '0;
				pos_q       <= '0;
				ovf_q       <= 1'b0;
				row_bytes_q <= '0;
			end else begin
				esc_q      <= esc_nx;
				enc_open_q <= enc_open_nx;
				enclosed_q <= enclosed_nx;
				pos_q      <= pos_nx;
				ovf_q      <= ovf_nx;
				if (is_term)
					start_q <= pos_nx;
				if (!row_full)
					row_bytes_q <= row_bytes_q + 1'b1;
			end
		end
	end

	a_start_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		start_q <= pos_q)
		else $error("field start beyond byte position");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> row_bytes_q == csf_pkg::ROW_CNT_W'(csf_pkg::MAX_ROW_BYTES))
		else $error("overflow flagged before row length limit");

endmodule
`default_nettype wire

### hdl/csf_queue.sv
// Two-entry request queue between parser and result stage.
`default_nettype none
module csf_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  csf_pkg::field_req_t  push_req,
	output logic                 full,
	input  wire                  pop,
	output logic                 empty,
	output csf_pkg::field_req_t  head
);

	csf_pkg::field_req_t             mem [csf_pkg::Q_DEPTH];
	logic [csf_pkg::Q_AW-1:0]        wr_ptr_q;
	logic [csf_pkg::Q_AW-1:0]        rd_ptr_q;
	logic [csf_pkg::Q_CW-1:0]        count_q;

	assign full  = (count_q == csf_pkg::Q_CW'(csf_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("request popped from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= csf_pkg::Q_CW'(csf_pkg::Q_DEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

### hdl/csf_back.sv
// Result stage: turns a field request into offset and length, holds the output.
`default_nettype none
module csf_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_empty,
	input  csf_pkg::field_req_t        head,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [csf_pkg::POS_W-1:0]  out_offset,
	output logic [csf_pkg::POS_W-1:0]  out_length,
	output logic                       out_last,
	output logic                       out_ovf
);

	localparam logic [csf_pkg::END_W-1:0] POS_MAX = {1'b0, {csf_pkg::POS_W{1'b1}}};

	logic                           valid_q;
	logic [csf_pkg::POS_W-1:0]      offset_q;
	logic [csf_pkg::POS_W-1:0]      length_q;
	logic                           last_q;
	logic                           ovf_q;

	logic [csf_pkg::END_W-1:0]      start_w;
	logic [csf_pkg::END_W-1:0]      len_raw;
	logic [csf_pkg::END_W-1:0]      off_w;
	logic [csf_pkg::END_W-1:0]      len_w;

	assign pop = ~q_empty & (~valid_q | out_ready);

	always_comb begin
		start_w = {1'b0, head.start};
		len_raw = (head.stop >= start_w) ? head.stop - start_w : '0;
		off_w   = start_w;
		len_w   = len_raw;
		// Enclosed field: drop the enclosure bytes at both ends.
		if (head.enclosed) begin
			off_w = start_w + 1'b1;
			len_w = (len_raw >= csf_pkg::END_W'(2)) ? len_raw - csf_pkg::END_W'(2) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || out_ready)
			valid_q <= pop;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			offset_q <= (off_w > POS_MAX) ? POS_MAX[csf_pkg::POS_W-1:0]
			                              : off_w[csf_pkg::POS_W-1:0];
			length_q <= (len_w > POS_MAX) ? POS_MAX[csf_pkg::POS_W-1:0]
			                              : len_w[csf_pkg::POS_W-1:0];
			last_q   <= head.last;
			ovf_q    <= head.ovf;
		end
	end

	assign out_valid  = valid_q;
	assign out_offset = offset_q;
	assign out_length = length_q;
	assign out_last   = last_q;
	assign out_ovf    = ovf_q;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q && $stable(offset_q) && $stable(length_q))
		else $error("result changed while stalled");

endmodule
`default_nettype wire

### hdl/csv_field_splitter_core.sv
// Top level of the CSV field splitter: registers, parser, queue, result stage.
//
//  port group   dir  role                      payload
//  s_*          in   row bytes, one a request  tdata[7:0]=data_byte, tlast=row_end
//  m_*          out  field results             tdata[15:0]=offset [31:16]=length,
//                                              tlast=last_field, tuser=row_overflow
//  p*           in   APB config, 3 registers   0x0 terminator, 0x4 enclosure, 0x8 escape
//
// One byte is accepted per cycle while the queue is not full; the parse state update is
// combinational compares and a 16-bit increment. m_tvalid for a field rises when its
// request, queued at the edge that accepts the byte ending it, is popped into the result
// registers. Reset clears all parse state and loads the register defaults.
// A stalled m_tready fills the two-entry queue, after which s_tready drops.
`default_nettype none
module csv_field_splitter_core (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [7:0]                  s_tdata,   // [7:0] data_byte
	input  wire                         s_tlast,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [31:0]                 m_tdata,   // [15:0] field_offset, [31:16] field_length
	output logic                        m_tlast,
	output logic                        m_tuser,   // [0] row_overflow
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [csf_pkg::APB_AW-1:0]  paddr,
	input  wire  [csf_pkg::APB_DW-1:0]  pwdata,
	output logic [csf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	csf_pkg::cfg_t        cfg;
	csf_pkg::field_req_t  req;
	csf_pkg::field_req_t  head;
	logic                 req_push;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	logic [15:0]          offset;
	logic [15:0]          length;

	csf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.req_push (req_push),
		.req      (req),
		.q_full   (q_full)
	);

	csf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (req_push),
		.push_req (req),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head)
	);

	csf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_offset (offset),
		.out_length (length),
		.out_last   (m_tlast),
		.out_ovf    (m_tuser)
	);

	assign m_tdata = {length, offset};

endmodule
`default_nettype wire

### tb/tb_csv_field_splitter_core.sv
// Self-checking testbench for csv_field_splitter_core: directed rows, random rows.
`timescale 1ns / 1ps
module tb_csv_field_splitter_core;

	localparam int          LIMIT        = 1_000_000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          HOLD_CYCLES  = 300;
	localparam logic [3:0]  SPARE_ADDR   = 4'hC;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] len;
		logic        lst;
		logic        ovf;
	} field_t;

	// how a directed row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_FIELD
	} row_chk_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		row_chk_t   chk;
		field_t     want;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tready  = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [csf_pkg::APB_AW-1:0] paddr  = '0;
	logic [csf_pkg::APB_DW-1:0] pwdata = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [31:0] m_tdata;
	wire         m_tlast;
	wire         m_tuser;
	wire  [csf_pkg::APB_DW-1:0] prdata;
	wire         pready;

	csv_field_splitter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// splitter state as predicted
	logic [7:0]  sep_char   = csf_pkg::TERM_RESET;
	logic [7:0]  quote_char = csf_pkg::ENC_RESET;
	logic [7:0]  esc_char   = csf_pkg::ESC_RESET;
	bit          in_escape, in_quote, quoted_field, row_over;
	int unsigned field_start, next_pos, row_count;

	field_t pending_fields[$];
	int     mismatches = 0;
	int     cycles     = 0;
	bit     src_idle   = 1'b1;
	logic   snk_idle   = 1'b1;
	logic   hold_req   = 1'b0;
	logic   hold_on    = 1'b0;

	// default registers: tab separates, zero encloses, backslash escapes
	dir_row_t dir_rows [0:25] = '{
		'{8'h61, 1'b0, CHK_NONE,  '0},
		'{8'h09, 1'b0, CHK_FIELD, '{16'd0, 16'd1, 1'b0, 1'b0}},
		'{8'h62, 1'b0, CHK_MODEL, '0},
		'{8'h63, 1'b1, CHK_FIELD, '{16'd2, 16'd2, 1'b1, 1'b0}},
		// lone zero byte opens an enclosure that never closes
		'{8'h00, 1'b1, CHK_FIELD, '{16'd1, 16'd0, 1'b1, 1'b0}},
		// row made of a terminator only: no empty field after it
		'{8'h09, 1'b1, CHK_FIELD, '{16'd0, 16'd0, 1'b1, 1'b0}},
		'{8'h5c, 1'b0, CHK_NONE,  '0},
		'{8'h09, 1'b0, CHK_NONE,  '0},
		'{8'h78, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b1, CHK_FIELD, '{16'd0, 16'd3, 1'b1, 1'b0}},
		'{8'h5c, 1'b0, CHK_MODEL, '0},
		'{8'h5c, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b1, CHK_FIELD, '{16'd0, 16'd2, 1'b1, 1'b0}},
		'{8'hff, 1'b0, CHK_MODEL, '0},
		'{8'h00, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b0, CHK_FIELD, '{16'd0, 16'd2, 1'b0, 1'b0}},
		'{8'h80, 1'b1, CHK_FIELD, '{16'd3, 16'd1, 1'b1, 1'b0}},
		'{8'h00, 1'b0, CHK_MODEL, '0},
		'{8'h61, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b0, CHK_NONE,  '0},
		'{8'h00, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b0, CHK_FIELD, '{16'd1, 16'd2, 1'b0, 1'b0}},
		'{8'h7a, 1'b1, CHK_FIELD, '{16'd5, 16'd1, 1'b1, 1'b0}},
		'{8'h00, 1'b0, CHK_MODEL, '0},
		'{8'h00, 1'b0, CHK_MODEL, '0},
		'{8'h09, 1'b1, CHK_FIELD, '{16'd1, 16'd0, 1'b1, 1'b0}}
	};

	function automatic logic [15:0] sat16(input int unsigned v);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic field_t field_from(input int unsigned stop, input bit lst);
		int unsigned off, len;
		field_t f;
		len = (stop >= field_start) ? stop - field_start : 0;
		off = field_start;
		if (quoted_field) begin
			off = off + 1;
			len = (len >= 2) ? len - 2 : 0;
		end
		f.off = sat16(off);
		f.len = sat16(len);
		f.lst = lst;
		f.ovf = row_over;
		return f;
	endfunction

	function automatic bit split_byte(input logic [7:0] ch, input logic last,
			output field_t f);
		int unsigned p, nxt;
		bit got;
		p   = next_pos;
		nxt = sat16(p + 1);
		got = 1'b0;
		f   = '0;
		if (row_count >= csf_pkg::MAX_ROW_BYTES)
			row_over = 1'b1;
		else
			row_count++;
		// escape wins over enclosure, enclosure over terminator
		if (ch == esc_char) begin
			in_escape = !in_escape;
		end else if (ch == quote_char && !in_escape && (p == field_start || in_quote)) begin
			in_quote = !in_quote;
			if (p == field_start)
				quoted_field = 1'b1;
		end else if (ch == sep_char && !in_quote && !in_escape) begin
			f            = field_from(p, last);
			got          = 1'b1;
			quoted_field = 1'b0;
			field_start  = nxt;
		end else begin
			in_escape = 1'b0;
		end
		next_pos = nxt;
		if (last) begin
			if (!got) begin
				f   = field_from(p + 1, 1'b1);
				got = 1'b1;
			end
			in_escape    = 1'b0;
			in_quote     = 1'b0;
			quoted_field = 1'b0;
			field_start  = 0;
			next_pos     = 0;
			row_over     = 1'b0;
			row_count    = 0;
		end
		return got;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] ch, input logic last, input row_chk_t chk,
			input field_t want);
		field_t f;
		bit got;
		if (src_idle && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		got = split_byte(ch, last, f);
		case (chk)
			CHK_MODEL: if (got) pending_fields.push_back(f);
			CHK_FIELD: pending_fields.push_back(want);
			default: ;
		endcase
	endtask

	// lets the block go quiet before a register write or the end
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		if (addr == {csf_pkg::REG_TERM, 2'b00})
			sep_char = val;
		else if (addr == {csf_pkg::REG_ENC, 2'b00})
			quote_char = val;
		else if (addr == {csf_pkg::REG_ESC, 2'b00})
			esc_char = val;
		if (addr == SPARE_ADDR) begin
			psel <= 1'b0;
		end else begin
			// read it back
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata[7:0] !== val)
				flag_mismatch($sformatf("reg 0x%h read 0x%h, wrote 0x%h", addr, prdata[7:0], val));
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	function automatic logic [7:0] any_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15) return sep_char;
		if (r < 27) return quote_char;
		if (r < 37) return esc_char;
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed rows of fields, some plain noise
	task automatic send_row(input bit noise, inout int sent);
		logic [7:0] row[$];
		int nf, k, j, n;
		bit quoted;
		if (noise) begin
			n = $urandom_range(1, 10);
			for (j = 0; j < n; j++) row.push_back(any_byte());
		end else begin
			nf = $urandom_range(1, 4);
			for (k = 0; k < nf; k++) begin
				quoted = ($urandom_range(2) == 0);
				if (quoted) row.push_back(quote_char);
				n = $urandom_range(0, 6);
				for (j = 0; j < n; j++) begin
					if ($urandom_range(9) == 0) begin
						row.push_back(esc_char);
						row.push_back(any_byte());
					end else begin
						row.push_back(8'($urandom_range(255)));
					end
				end
				if (quoted && $urandom_range(9) != 0) row.push_back(quote_char);
				if (k < nf - 1) row.push_back(sep_char);
			end
			if ($urandom_range(4) == 0 || row.size() == 0) row.push_back(sep_char);
		end
		for (j = 0; j < row.size(); j++)
			send_byte(row[j], j == row.size() - 1, CHK_MODEL, '0);
		sent += row.size();
	endtask

	task automatic run_phase(input logic [7:0] sep, input logic [7:0] quote,
			input logic [7:0] esc, input int items, input bit idle, input bit squeeze);
		int sent, j;
		drain();
		write_reg({csf_pkg::REG_TERM, 2'b00}, sep);
		write_reg({csf_pkg::REG_ENC, 2'b00}, quote);
		write_reg({csf_pkg::REG_ESC, 2'b00}, esc);
		src_idle = idle;
		snk_idle <= idle;
		sent = 0;
		if (squeeze) begin
			// receiver holds off while a row of bare terminators keeps coming
			hold_req <= 1'b1;
			for (j = 0; j < 40; j++)
				send_byte(sep, j == 39, CHK_MODEL, '0);
		end
		while (sent < items)
			send_row($urandom_range(3) == 0, sent);
	endtask

	initial begin : stimulus
		int i;
		logic [7:0] r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_rows); i++)
			send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].chk, dir_rows[i].want);

		drain();
		write_reg(SPARE_ADDR, 8'h2c);
		run_phase(8'h2c, 8'h22, 8'h5c, 200, 1'b1, 1'b0);
		run_phase(8'h00, 8'hff, 8'h7f, 200, 1'b1, 1'b0);
		run_phase(8'hff, 8'h00, 8'h00, 200, 1'b1, 1'b0);
		r = 8'($urandom_range(0, 254));
		run_phase(r, r, 8'hff, 150, 1'b1, 1'b0);
		run_phase(8'h09, 8'h22, 8'h5c, 250, 1'b0, 1'b1);

		drain();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : receiver_hold
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin : field_check
		field_t want, seen;
		if (m_tvalid && m_tready) begin
			seen = {m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser};
			if (pending_fields.size() == 0) begin
				flag_mismatch($sformatf("unexpected field off %0d len %0d", seen.off, seen.len));
			end else begin
				want = pending_fields.pop_front();
				if (seen.off !== want.off)
					flag_mismatch($sformatf("offset %0d, want %0d", seen.off, want.off));
				if (seen.len !== want.len)
					flag_mismatch($sformatf("length %0d, want %0d", seen.len, want.len));
				if (seen.lst !== want.lst)
					flag_mismatch($sformatf("last_field %b, want %b", seen.lst, want.lst));
				if (seen.ovf !== want.ovf)
					flag_mismatch($sformatf("row_overflow %b, want %b", seen.ovf, want.ovf));
			end
		end
		m_tready <= !hold_on && (!snk_idle || $urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
